// File: hw/rtl/median_filter_3x3_defines.svh
// Assertion macros shared by the queue and top-level RTL files.
// Define NO_ASSERTIONS to compile them out.
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MF3_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("mf3 assertion failed");

`define MF3_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mf3 assertion failed");

`define MF3_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mf3 assertion failed");

`else

`define MF3_ASSERT(label, prop)
`define MF3_ASSERT_IMPLY(label, ante, cons)
`define MF3_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/mf3_pkg.sv
package mf3_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = 16;
   localparam int PIX_W       = 8;
   localparam int WIDTH_W     = 11;
   localparam int MIN_SIZE    = 3;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef logic [PIX_W-1:0] pixel_type;

   // position and routing info of one request as it moves down the pipe
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] row_up;
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] col_first;
      logic             has_out;
      logic             last_col;
      logic             last_row;
      logic             pass_mid;
      logic             pass_prev;
      pixel_type        px;
   } info_type;

   // one window column, sorted
   typedef struct packed {
      pixel_type lo;
      pixel_type md;
      pixel_type hi;
   } column_type;

   // one queued request: holds everything for its one to three results
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] row_up;
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] col_first;
      pixel_type        value;
      pixel_type        mid;
      pixel_type        px;
      logic             last_col;
      logic             last_row;
   } entry_type;

endpackage

// File: hw/rtl/mf3_ram.sv
module mf3_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/mf3_median.sv
module mf3_median (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  mf3_pkg::info_type   in_info,
   input  mf3_pkg::pixel_type  in_top,
   input  mf3_pkg::pixel_type  in_mid,
   output logic [1:0]          busy_count,
   output logic                out_valid,
   output mf3_pkg::entry_type  out_entry
);

   import mf3_pkg::*;

   function automatic pixel_type max2(input pixel_type a, input pixel_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pixel_type min2(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pixel_type med3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // stage 2: sorted column of the current request
   logic       s2_valid_ff;
   info_type   s2_info_ff;
   column_type s2_col_ff;
   pixel_type  s2_mid_ff;

   // window: the two previous columns, plus middle pixel of the previous request
   column_type col_a_ff;
   column_type col_b_ff;
   pixel_type  prev_mid_ff;

   // stage 3: merged candidates
   logic       s3_valid_ff;
   info_type   s3_info_ff;
   pixel_type  s3_lo_ff;
   pixel_type  s3_md_ff;
   pixel_type  s3_hi_ff;
   pixel_type  s3_mid_ff;
   pixel_type  s3_prev_ff;

   column_type col_in;
   pixel_type  lo_in;
   pixel_type  md_in;
   pixel_type  hi_in;
   pixel_type  median;
   pixel_type  value;

   // sort the incoming column (top, mid, pixel)
   always_comb begin
      col_in.lo = min2(min2(in_top, in_mid), in_info.px);
      col_in.hi = max2(max2(in_top, in_mid), in_info.px);
      col_in.md = med3(in_top, in_mid, in_info.px);
   end

   // median of nine = med3(max of lows, med of meds, min of highs)
   always_comb begin
      lo_in = max2(max2(col_a_ff.lo, col_b_ff.lo), s2_col_ff.lo);
      md_in = med3(col_a_ff.md, col_b_ff.md, s2_col_ff.md);
      hi_in = min2(min2(col_a_ff.hi, col_b_ff.hi), s2_col_ff.hi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= in_valid;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s2_info_ff <= in_info;
         s2_col_ff  <= col_in;
         s2_mid_ff  <= in_mid;
      end
      if (s2_valid_ff) begin
         col_a_ff    <= col_b_ff;
         col_b_ff    <= s2_col_ff;
         prev_mid_ff <= s2_mid_ff;
         s3_info_ff  <= s2_info_ff;
         s3_lo_ff    <= lo_in;
         s3_md_ff    <= md_in;
         s3_hi_ff    <= hi_in;
         s3_mid_ff   <= s2_mid_ff;
         s3_prev_ff  <= prev_mid_ff;
      end
   end

   always_comb begin
      median = med3(s3_lo_ff, s3_md_ff, s3_hi_ff);
      if (s3_info_ff.pass_mid) begin
         value = s3_mid_ff;
      end else if (s3_info_ff.pass_prev) begin
         value = s3_prev_ff;
      end else begin
         value = median;
      end
   end

   always_comb begin
      out_entry.row       = s3_info_ff.row;
      out_entry.row_up    = s3_info_ff.row_up;
      out_entry.col       = s3_info_ff.col;
      out_entry.col_first = s3_info_ff.col_first;
      out_entry.value     = value;
      out_entry.mid       = s3_mid_ff;
      out_entry.px        = s3_info_ff.px;
      out_entry.last_col  = s3_info_ff.last_col;
      out_entry.last_row  = s3_info_ff.last_row;
   end

   assign out_valid  = s3_valid_ff & s3_info_ff.has_out;
   assign busy_count = {1'b0, s2_valid_ff} + {1'b0, s3_valid_ff};

endmodule

// File: hw/rtl/mf3_queue.sv
module mf3_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push_valid,
   input  mf3_pkg::entry_type              push_entry,
   output logic [mf3_pkg::QCNT_W-1:0]      count,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mf3_pkg::ROW_W-1:0]       rsp_out_row,
   output logic [mf3_pkg::COL_W-1:0]       rsp_out_col,
   output logic [mf3_pkg::PIX_W-1:0]       rsp_out_value,
   output logic                            rsp_last_in_run
);

   import mf3_pkg::*;

   `include "median_filter_3x3_defines.svh"

   typedef enum logic [2:0] {
      PH_FIRST  = 3'b001,
      PH_RIGHT  = 3'b010,
      PH_BOTTOM = 3'b100
   } phase_type;

   localparam logic [QCNT_W-1:0] FULL = QCNT_W'(QUEUE_DEPTH);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   phase_type         phase_ff;
   phase_type         phase_in;

   entry_type head;
   logic      deliver;
   logic      final_res;
   logic      pop;

   assign head      = mem_ff[rd_ptr_ff];
   assign rsp_valid = (count_ff != '0);
   assign deliver   = rsp_valid & ~rsp_stall;

   always_comb begin
      case (phase_ff)
         PH_FIRST: begin
            rsp_out_row   = head.row_up;
            rsp_out_col   = head.col_first;
            rsp_out_value = head.value;
            final_res     = ~head.last_col & ~head.last_row;
            phase_in      = head.last_col ? PH_RIGHT :
                            head.last_row ? PH_BOTTOM : PH_FIRST;
         end
         PH_RIGHT: begin
            rsp_out_row   = head.row_up;
            rsp_out_col   = head.col;
            rsp_out_value = head.mid;
            final_res     = ~head.last_row;
            phase_in      = head.last_row ? PH_BOTTOM : PH_FIRST;
         end
         PH_BOTTOM: begin
            rsp_out_row   = head.row;
            rsp_out_col   = head.col;
            rsp_out_value = head.px;
            final_res     = 1'b1;
            phase_in      = PH_FIRST;
         end
         default: begin
            rsp_out_row   = head.row_up;
            rsp_out_col   = head.col_first;
            rsp_out_value = head.value;
            final_res     = 1'b1;
            phase_in      = PH_FIRST;
         end
      endcase
   end

   assign rsp_last_in_run = final_res;
   assign pop             = deliver & final_res;
   assign count_in        = count_ff + QCNT_W'(push_valid) - QCNT_W'(pop);
   assign count           = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= PH_FIRST;
      end else begin
         count_ff <= count_in;
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (deliver) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `MF3_ASSERT_IMPLY(a_no_overflow, push_valid, count_ff != FULL)
   `MF3_ASSERT_IMPLY(a_right_phase, phase_ff == PH_RIGHT, rsp_valid && head.last_col)
   `MF3_ASSERT_IMPLY(a_bottom_phase, phase_ff == PH_BOTTOM, rsp_valid && head.last_row)

endmodule

// File: hw/rtl/median_filter_3x3.sv
// 3x3 median filter over a raster-order stream of 8-bit pixels. Frame size comes from
// csr_index 0 (width, 3..1024, reset 640) and 1 (height, 3..65535, reset 480); write them
// only while the block is idle. Results leave one row late, each tagged with its row and
// column; first/last rows and columns pass the original pixel through. A request on row r>=1
// gives one result, two at the end of a row, and one more each on the last row; row-0
// requests give none, and rsp_last_in_run marks the last result of each request. Requests
// are taken one per clock while req_stall is low: the line stores are one RAM with a single
// read and a single write port per cycle, and the median runs in two registered compare
// stages. Results leave at one per clock while rsp_stall is low, through an 8-deep request
// queue, so long runs of multi-result requests (row ends, last row) throttle the input to
// the output rate. No clearing pass is needed after reset.
module median_filter_3x3 (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [mf3_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mf3_pkg::PIX_W-1:0]          req_pixel,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mf3_pkg::ROW_W-1:0]          rsp_out_row,
   output logic [mf3_pkg::COL_W-1:0]          rsp_out_col,
   output logic [mf3_pkg::PIX_W-1:0]          rsp_out_value,
   output logic                               rsp_last_in_run
);

   import mf3_pkg::*;

   `include "median_filter_3x3_defines.svh"

   localparam logic [WIDTH_W-1:0] WIDTH_LO = WIDTH_W'(MIN_SIZE);
   localparam logic [WIDTH_W-1:0] WIDTH_HI = WIDTH_W'(MAX_WIDTH);
   localparam logic [ROW_W-1:0]   HEIGHT_LO = ROW_W'(MIN_SIZE);

   // config registers
   logic [WIDTH_W-1:0] image_width_ff;
   logic [ROW_W-1:0]   image_height_ff;

   // position of the next request
   logic [ROW_W-1:0]   row_count_ff;
   logic [ROW_W-1:0]   row_count_in;
   logic [COL_W-1:0]   col_count_ff;
   logic [COL_W-1:0]   col_count_in;

   // stage 1: line store read in flight
   logic               s1_valid_ff;
   info_type           s1_info_ff;

   logic               req_accept;
   logic [WIDTH_W-1:0] width_eff;
   logic [WIDTH_W-1:0] width_m1;
   logic [ROW_W-1:0]   height_eff;
   logic [ROW_W-1:0]   height_m1;
   logic [COL_W-1:0]   col_cur;
   logic               last_col;
   logic               last_row;
   info_type           s0_info;

   logic [2*PIX_W-1:0] line_rd;
   pixel_type          line_top;
   pixel_type          line_mid;

   logic [1:0]         med_busy;
   logic               med_valid;
   entry_type          med_entry;
   logic [QCNT_W-1:0]  q_count;
   logic [QCNT_W:0]    occupancy;

   assign req_accept = req_valid & ~req_stall;

   // ---- configuration writes ----
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_W'(640);
         image_height_ff <= ROW_W'(480);
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- stage 0: clamp the frame size and place the request ----
   always_comb begin
      if (image_width_ff < WIDTH_LO) begin
         width_eff = WIDTH_LO;
      end else if (image_width_ff > WIDTH_HI) begin
         width_eff = WIDTH_HI;
      end else begin
         width_eff = image_width_ff;
      end
      height_eff = (image_height_ff < HEIGHT_LO) ? HEIGHT_LO : image_height_ff;
      width_m1   = width_eff - 1'b1;
      height_m1  = height_eff - 1'b1;

      // a column counter left past the edge by a width change ends the row
      if ({1'b0, col_count_ff} >= width_eff) begin
         col_cur = width_m1[COL_W-1:0];
      end else begin
         col_cur = col_count_ff;
      end
      last_col = (col_cur == width_m1[COL_W-1:0]);
      last_row = (row_count_ff >= height_m1);

      if (last_col) begin
         col_count_in = '0;
         row_count_in = last_row ? '0 : row_count_ff + 1'b1;
      end else begin
         col_count_in = col_cur + 1'b1;
         row_count_in = row_count_ff;
      end
   end

   always_comb begin
      s0_info.row       = row_count_ff;
      s0_info.row_up    = row_count_ff - 1'b1;
      s0_info.col       = col_cur;
      s0_info.col_first = (col_cur == '0) ? '0 : col_cur - 1'b1;
      s0_info.has_out   = (row_count_ff != '0);
      s0_info.last_col  = last_col;
      s0_info.last_row  = last_row;
      // left border repeats the row-above pixel at this column
      s0_info.pass_mid  = (col_cur == '0);
      // second row and second column pass the previous middle pixel through
      s0_info.pass_prev = (row_count_ff == ROW_W'(1)) || (col_cur == COL_W'(1));
      s0_info.px        = req_pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         col_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
         if (req_accept) begin
            row_count_ff <= row_count_in;
            col_count_ff <= col_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_info_ff <= s0_info;
      end
   end

   // ---- line stores: both rows packed in one word, {two above, above} ----
   // Read at the request's column in stage 0, then written back shifted in stage 1.
   mf3_ram #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (2 * PIX_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_info_ff.col),
      .wr_data ({line_mid, s1_info_ff.px}),
      .rd_en   (req_accept),
      .rd_addr (col_cur),
      .rd_data (line_rd)
   );

   assign line_top = line_rd[2*PIX_W-1:PIX_W];
   assign line_mid = line_rd[PIX_W-1:0];

   // ---- stages 2 and 3: window and median ----
   mf3_median u_median (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid_ff),
      .in_info    (s1_info_ff),
      .in_top     (line_top),
      .in_mid     (line_mid),
      .busy_count (med_busy),
      .out_valid  (med_valid),
      .out_entry  (med_entry)
   );

   // ---- result queue and output sequencing ----
   mf3_queue u_queue (
      .clock           (clock),
      .reset           (reset),
      .push_valid      (med_valid),
      .push_entry      (med_entry),
      .count           (q_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_value   (rsp_out_value),
      .rsp_last_in_run (rsp_last_in_run)
   );

   // Credit check: every request in the pipe has a queue slot reserved.
   assign occupancy = {1'b0, q_count} + (QCNT_W+1)'(s1_valid_ff) + (QCNT_W+1)'(med_busy);
   assign req_stall = (occupancy >= (QCNT_W+1)'(QUEUE_DEPTH));

   `MF3_ASSERT(a_credit, occupancy <= (QCNT_W+1)'(QUEUE_DEPTH))
   `MF3_ASSERT_NEXT(a_row_wrap, req_accept && last_col, col_count_ff == '0)

endmodule

// File: tb/median_filter_3x3_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register ports of the median filter,
// predicts each result and compares it with what the block sends.
module median_filter_3x3_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [mf3_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [mf3_pkg::PIX_W-1:0]         req_pixel,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [mf3_pkg::ROW_W-1:0]         rsp_out_row,
   input  logic [mf3_pkg::COL_W-1:0]         rsp_out_col,
   input  logic [mf3_pkg::PIX_W-1:0]         rsp_out_value,
   input  logic                              rsp_last_in_run,
   output int                                pending,
   output int                                fail_count
);

   typedef struct packed {
      logic [mf3_pkg::ROW_W-1:0] row;
      logic [mf3_pkg::COL_W-1:0] col;
      logic [mf3_pkg::PIX_W-1:0] value;
      logic                      last;
   } out_pixel_type;

   out_pixel_type filtered_q[$];
   out_pixel_type want;

   // predictor state
   logic [mf3_pkg::WIDTH_W-1:0] width_reg;
   logic [mf3_pkg::ROW_W-1:0]   height_reg;
   logic [mf3_pkg::PIX_W-1:0]   line_above [mf3_pkg::MAX_WIDTH];
   logic [mf3_pkg::PIX_W-1:0]   line_two_above [mf3_pkg::MAX_WIDTH];
   logic [mf3_pkg::PIX_W-1:0]   win_cols [6];  // top/mid/bottom of the two previous columns
   logic [mf3_pkg::ROW_W-1:0]   row_pos;
   logic [mf3_pkg::COL_W-1:0]   col_pos;
   int                          errors = 0;

   // value v[i] is the median when at most four lie below it and at least five at or below it
   function automatic logic [7:0] median_of_nine(input logic [8:0][7:0] v);
      int         below;
      int         not_above;
      logic [7:0] m;
      m = v[0];
      for (int i = 0; i < 9; i++) begin
         below     = 0;
         not_above = 0;
         for (int j = 0; j < 9; j++) begin
            if (v[j] < v[i]) below++;
            if (v[j] <= v[i]) not_above++;
         end
         if (below <= 4 && not_above >= 5) m = v[i];
      end
      return m;
   endfunction

   function automatic out_pixel_type pack_pixel(input logic [31:0] row, input logic [31:0] col,
                                                input logic [7:0] value);
      out_pixel_type p;
      p.row   = row[mf3_pkg::ROW_W-1:0];
      p.col   = col[mf3_pkg::COL_W-1:0];
      p.value = value;
      p.last  = 1'b0;
      return p;
   endfunction

   // one accepted pixel: queue its results, then advance the window and counters
   task automatic filter_pixel(input logic [7:0] px);
      logic [31:0]               w;
      logic [31:0]               h;
      logic [31:0]               r;
      logic [31:0]               c;
      logic [mf3_pkg::COL_W-1:0] ci;
      logic [31:0]               nxt;
      logic [7:0]                top;
      logic [7:0]                mid;
      logic [7:0]                v;
      logic [8:0][7:0]           win;
      logic                      last_col;
      logic                      last_row;
      out_pixel_type             res [3];
      int                        n;
      w = 32'(width_reg);
      if (w < mf3_pkg::MIN_SIZE) w = mf3_pkg::MIN_SIZE;
      if (w > mf3_pkg::MAX_WIDTH) w = mf3_pkg::MAX_WIDTH;
      h = 32'(height_reg);
      if (h < mf3_pkg::MIN_SIZE) h = mf3_pkg::MIN_SIZE;
      r = 32'(row_pos);
      c = 32'(col_pos);
      if (c >= w) c = w - 1;
      ci = c[mf3_pkg::COL_W-1:0];
      last_col = (c >= w - 1);
      last_row = (r >= h - 1);
      top = line_two_above[ci];
      mid = line_above[ci];
      n = 0;
      if (r >= 1) begin
         if (c == 0) begin
            res[n] = pack_pixel(r - 1, 0, mid);
            n++;
         end else begin
            if (r == 1 || c == 1) begin
               v = win_cols[4];
            end else begin
               for (int i = 0; i < 6; i++) win[i] = win_cols[i];
               win[6] = top;
               win[7] = mid;
               win[8] = px;
               v = median_of_nine(win);
            end
            res[n] = pack_pixel(r - 1, c - 1, v);
            n++;
         end
         if (last_col) begin
            res[n] = pack_pixel(r - 1, c, mid);
            n++;
         end
         if (last_row) begin
            res[n] = pack_pixel(r, c, px);
            n++;
         end
         for (int k = 0; k < n; k++) begin
            res[k].last = (k == n - 1);
            filtered_q.push_back(res[k]);
         end
      end
      line_two_above[ci] = mid;
      line_above[ci]     = px;
      win_cols[0] = win_cols[3];
      win_cols[1] = win_cols[4];
      win_cols[2] = win_cols[5];
      win_cols[3] = top;
      win_cols[4] = mid;
      win_cols[5] = px;
      if (last_col) begin
         col_pos = '0;
         nxt = r + 1;
         row_pos = last_row ? '0 : nxt[mf3_pkg::ROW_W-1:0];
      end else begin
         nxt = c + 1;
         col_pos = nxt[mf3_pkg::COL_W-1:0];
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         filtered_q.delete();
         width_reg  = 11'd640;
         height_reg = 16'd480;
         row_pos    = '0;
         col_pos    = '0;
         for (int i = 0; i < 6; i++) win_cols[i] = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (filtered_q.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected result row %0d col %0d value %0d last %0b",
                           $time, rsp_out_row, rsp_out_col, rsp_out_value, rsp_last_in_run);
               errors++;
            end else begin
               want = filtered_q.pop_front();
               if (rsp_out_row !== want.row || rsp_out_col !== want.col ||
                   rsp_out_value !== want.value || rsp_last_in_run !== want.last) begin
                  if (errors < 10)
                     $display({"%0t: mismatch exp row %0d col %0d value %0d last %0b,",
                               " got row %0d col %0d value %0d last %0b"},
                              $time, want.row, want.col, want.value, want.last,
                              rsp_out_row, rsp_out_col, rsp_out_value, rsp_last_in_run);
                  errors++;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == mf3_pkg::CSR_IMAGE_WIDTH)
               width_reg = csr_wdata[mf3_pkg::WIDTH_W-1:0];
            else if (csr_index == mf3_pkg::CSR_IMAGE_HEIGHT)
               height_reg = csr_wdata;
         end
         if (req_valid && !req_stall) filter_pixel(req_pixel);
      end
      pending    <= filtered_q.size();
      fail_count <= errors;
   end

endmodule

// File: tb/tb_median_filter_3x3.sv
`timescale 1ns / 1ps

// Top of the median filter bench: drives pixel frames and register writes,
// throttles both channels at random, and gives the verdict. All prediction
// and comparison lives in the checker instance.
module tb_median_filter_3x3;

   localparam int ITEM_TARGET   = 310;     // random part stops once this many requests went in
   localparam int SETTLE_CYCLES = 12;      // extra wait for the pipe to drain; generous margin
   localparam int CYCLE_LIMIT   = 200000;  // watchdog

   logic                              clock;
   logic                              reset;
   logic                              csr_we;
   logic [mf3_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [mf3_pkg::CSR_DATA_W-1:0]    csr_wdata;
   logic                              req_valid;
   logic                              req_stall;
   logic [mf3_pkg::PIX_W-1:0]         req_pixel;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [mf3_pkg::ROW_W-1:0]         rsp_out_row;
   logic [mf3_pkg::COL_W-1:0]         rsp_out_col;
   logic [mf3_pkg::PIX_W-1:0]         rsp_out_value;
   logic                              rsp_last_in_run;

   int pending;
   int fail_count;
   int sent      = 0;   // requests accepted so far
   int cycles    = 0;
   int send_calm = 0;   // remaining requests sent back to back
   int recv_calm = 0;   // remaining results taken without stall

   median_filter_3x3 dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_value   (rsp_out_value),
      .rsp_last_in_run (rsp_last_in_run)
   );

   median_filter_3x3_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_value   (rsp_out_value),
      .rsp_last_in_run (rsp_last_in_run),
      .pending         (pending),
      .fail_count      (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: a hang or a lost result ends here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** median_filter_3x3: FAILED **");
         $finish;
      end
   end

   // Idle gap before the next transfer, drawn at random. Now and then a calm stretch
   // of 10..30 transfers with no idling at all.
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) calm = $urandom_range(10, 30);
      return $urandom_range(0, 4);
   endfunction

   // mostly uniform pixels; some extremes and near-ties so the median sort sees duplicates
   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         1:       return 8'(100 + $urandom_range(0, 3));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // result side: stall for a drawn number of cycles, then take one result
   initial begin
      int gap;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         gap = draw_gap(recv_calm);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // One request; valid stays high across back-to-back requests.
   // Returns at the edge where the request is taken.
   task automatic send_pixel(input logic [7:0] px);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic send_run(input int count);
      for (int i = 0; i < count; i++) send_pixel(pick_pixel());
   endtask

   // Drop valid, wait until every predicted result came back, then let the
   // pipe empty of row-0 requests, which leave nothing to wait on.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mf3_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mf3_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int w;
      int h;
      int w2;
      int w2_eff;
      int rows_before;
      int split;
      int row_rest;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_pixel <= '0;
      csr_we    <= 1'b0;
      csr_index <= mf3_pkg::CSR_IMAGE_WIDTH;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // width 0 and height 1 both clamp to 3: smallest frame, one interior pixel.
      // Extremes and alternating bit patterns around it.
      write_reg(mf3_pkg::CSR_IMAGE_WIDTH, 16'd0);
      write_reg(mf3_pkg::CSR_IMAGE_HEIGHT, 16'd1);
      send_pixel(8'hFF);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h55);
      send_pixel(8'hAA);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h00);
      send_pixel(8'h80);
      settle();

      // upper data bits above the 11-bit width register are dropped: reads as 4.
      // Height 2 clamps to 3. Random content.
      write_reg(mf3_pkg::CSR_IMAGE_WIDTH, 16'hF804);
      write_reg(mf3_pkg::CSR_IMAGE_HEIGHT, 16'd2);
      send_run(12);
      settle();

      // --- random frames, each left complete so counters start at zero ---
      while (sent < ITEM_TARGET) begin
         case ($urandom_range(0, 3))
            0, 1: begin
               // whole frame, mostly narrow
               w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
               h = $urandom_range(3, 5);
               write_reg(mf3_pkg::CSR_IMAGE_WIDTH, 16'(w));
               write_reg(mf3_pkg::CSR_IMAGE_HEIGHT, 16'(h));
               send_run(w * h);
               settle();
            end
            2: begin
               // Tallest height, then cut it mid-frame: the current row is at
               // or past the new last row, so it closes the frame.
               w           = $urandom_range(3, 10);
               rows_before = $urandom_range(2, 4);
               split       = $urandom_range(0, w - 1);
               write_reg(mf3_pkg::CSR_IMAGE_WIDTH, 16'(w));
               write_reg(mf3_pkg::CSR_IMAGE_HEIGHT, 16'hFFFF);
               send_run(rows_before * w + split);
               settle();
               write_reg(mf3_pkg::CSR_IMAGE_HEIGHT, 16'($urandom_range(0, rows_before + 1)));
               send_run(w - split);
               settle();
            end
            default: begin
               // Narrow the width mid-row. A column counter at or past the new
               // last column ends the row at once. The wide case parks in row 0
               // of a maximum-width (or clamped) frame, so no result is lost.
               h           = $urandom_range(3, 4);
               rows_before = $urandom_range(0, h - 2);
               if (rows_before == 0 && $urandom_range(0, 1) == 1) begin
                  case ($urandom_range(0, 2))
                     0:       w = mf3_pkg::MAX_WIDTH;
                     1:       w = 2047;
                     default: w = 1500;
                  endcase
                  split = $urandom_range(20, 60);
               end else begin
                  w     = $urandom_range(4, 12);
                  split = $urandom_range(1, w - 1);
               end
               write_reg(mf3_pkg::CSR_IMAGE_WIDTH, 16'(w));
               write_reg(mf3_pkg::CSR_IMAGE_HEIGHT, 16'(h));
               send_run(rows_before * w + split);
               settle();
               // new width never exceeds the columns already written above
               w2     = $urandom_range(0, (split < 12) ? split : 12);
               w2_eff = (w2 < mf3_pkg::MIN_SIZE) ? mf3_pkg::MIN_SIZE : w2;
               write_reg(mf3_pkg::CSR_IMAGE_WIDTH, 16'(w2));
               row_rest = (split >= w2_eff - 1) ? 1 : w2_eff - split;
               send_run(row_rest + (h - rows_before - 1) * w2_eff);
               settle();
            end
         endcase
      end

      // settle() above already waited out the pipe; wait for the checker's registered
      // count to cover the last comparisons
      @(posedge clock);
      if (fail_count == 0) begin
         $display("** median_filter_3x3: PASSED **");
      end else begin
         $display("** median_filter_3x3: FAILED **");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/mf3_pkg.sv
hw/rtl/mf3_ram.sv
hw/rtl/mf3_median.sv
hw/rtl/mf3_queue.sv
hw/rtl/median_filter_3x3.sv
tb/median_filter_3x3_checker.sv
tb/tb_median_filter_3x3.sv
